FILE: src/ipu_pkg.sv
// Shared types, constants and microprogram for the integer property unit.
// Used by ipu_div and integer_property_unit; depends on nothing else.
package ipu_pkg;

	// Operand width that is examined (low bits of the operand, sign-extended)
	localparam int DATA_WIDTH = 32;

	// Stream field widths
	localparam int OPCODE_W    = 3;
	localparam int OPERAND_W   = 32;
	localparam int NUM_W       = 34;
	localparam int SIGN_W      = 2;
	localparam int IN_FIELDS_W = OPCODE_W + OPERAND_W;
	localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 1 + 1 + SIGN_W + NUM_W;
	localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Datapath widths
	localparam int VAL_W = DATA_WIDTH - 1;           // positive magnitude
	localparam int DIV_W = (DATA_WIDTH + 1) / 2;     // trial divisor and remainder
	localparam int SQ_W  = DATA_WIDTH + 1;           // square of trial divisor
	localparam int CNT_W = $clog2(VAL_W + 1);        // divider bit counter

	// Divide by ten as a reciprocal multiply: q = (t * ceil(2^35 / 10)) >> 35
	localparam int               RECIP_W     = 32;
	localparam int               PROD_W      = VAL_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP10   = 32'hCCCC_CCCD;
	localparam int               RECIP_SHIFT = 35;

	// Algorithm constants
	localparam logic [DIV_W-1:0] D_FIRST  = DIV_W'(3);
	localparam logic [DIV_W-1:0] D_STEP   = DIV_W'(2);
	localparam logic [SQ_W-1:0]  SQ_FIRST = SQ_W'(9);
	localparam logic [SQ_W-1:0]  SQ_STEP  = SQ_W'(4);
	localparam logic [VAL_W-1:0] VAL_ONE  = VAL_W'(1);
	localparam logic [VAL_W-1:0] VAL_FOUR = VAL_W'(4);

	// Opcodes
	localparam logic [OPCODE_W-1:0] OP_PARITY = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_PRIME  = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_PALIN  = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_SIGN   = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_REV    = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_DSUM   = 3'd5;

	// Sign classes
	localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'd0;
	localparam logic [SIGN_W-1:0] SIGN_POS  = 2'd1;
	localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'd2;

	// Micro-sequencer
	localparam int UPC_W = 5;
	typedef logic [UPC_W-1:0] upc_t;

	localparam upc_t U_IDLE     = UPC_W'(0);
	localparam upc_t U_DISPATCH = UPC_W'(1);
	localparam upc_t U_PARITY   = UPC_W'(2);
	localparam upc_t U_SIGN     = UPC_W'(3);
	localparam upc_t U_INVALID  = UPC_W'(4);
	localparam upc_t U_P_LE1    = UPC_W'(5);
	localparam upc_t U_P_LT4    = UPC_W'(6);
	localparam upc_t U_P_EVEN   = UPC_W'(7);
	localparam upc_t U_P_LOOP   = UPC_W'(8);
	localparam upc_t U_P_DIV    = UPC_W'(9);
	localparam upc_t U_P_WAIT   = UPC_W'(10);
	localparam upc_t U_P_TEST   = UPC_W'(11);
	localparam upc_t U_P_NEXT   = UPC_W'(12);
	localparam upc_t U_P_YES    = UPC_W'(13);
	localparam upc_t U_D_LOOP   = UPC_W'(14);
	localparam upc_t U_D_DIV    = UPC_W'(15);
	localparam upc_t U_D_ACC    = UPC_W'(16);
	localparam upc_t U_D_END    = UPC_W'(17);
	localparam upc_t U_FINISH   = UPC_W'(18);
	localparam upc_t U_EMIT     = UPC_W'(19);

	// Datapath action of one control word
	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_PARITY,
		ACT_SIGN,
		ACT_INVALID,
		ACT_VERDICT,
		ACT_DIV_D,
		ACT_DIV_TEN,
		ACT_STEP_D,
		ACT_DIGIT,
		ACT_DIGIT_END,
		ACT_EMIT
	} act_t;

	// Jump condition of one control word
	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NOSTART,
		C_DISPATCH,
		C_LE1,
		C_LT4,
		C_EVEN,
		C_SQ_GT,
		C_DIV_BUSY,
		C_REM_ZERO,
		C_T_ZERO,
		C_OUT_FULL
	} cond_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		upc_t  target;
	} uword_t;

	// Control store
	function automatic uword_t urom(input upc_t a);
		uword_t w;
		w = '{act: ACT_NONE, cond: C_NEVER, target: U_IDLE};
		case (a)
			U_IDLE:     w = '{act: ACT_NONE,      cond: C_NOSTART,  target: U_IDLE};
			U_DISPATCH: w = '{act: ACT_NONE,      cond: C_DISPATCH, target: U_IDLE};
			U_PARITY:   w = '{act: ACT_PARITY,    cond: C_ALWAYS,   target: U_FINISH};
			U_SIGN:     w = '{act: ACT_SIGN,      cond: C_ALWAYS,   target: U_FINISH};
			U_INVALID:  w = '{act: ACT_INVALID,   cond: C_ALWAYS,   target: U_FINISH};
			U_P_LE1:    w = '{act: ACT_NONE,      cond: C_LE1,      target: U_FINISH};
			U_P_LT4:    w = '{act: ACT_NONE,      cond: C_LT4,      target: U_P_YES};
			U_P_EVEN:   w = '{act: ACT_NONE,      cond: C_EVEN,     target: U_FINISH};
			U_P_LOOP:   w = '{act: ACT_NONE,      cond: C_SQ_GT,    target: U_P_YES};
			U_P_DIV:    w = '{act: ACT_DIV_D,     cond: C_NEVER,    target: U_IDLE};
			U_P_WAIT:   w = '{act: ACT_NONE,      cond: C_DIV_BUSY, target: U_P_WAIT};
			U_P_TEST:   w = '{act: ACT_NONE,      cond: C_REM_ZERO, target: U_FINISH};
			U_P_NEXT:   w = '{act: ACT_STEP_D,    cond: C_ALWAYS,   target: U_P_LOOP};
			U_P_YES:    w = '{act: ACT_VERDICT,   cond: C_ALWAYS,   target: U_FINISH};
			U_D_LOOP:   w = '{act: ACT_NONE,      cond: C_T_ZERO,   target: U_D_END};
			U_D_DIV:    w = '{act: ACT_DIV_TEN,   cond: C_NEVER,    target: U_IDLE};
			U_D_ACC:    w = '{act: ACT_DIGIT,     cond: C_ALWAYS,   target: U_D_LOOP};
			U_D_END:    w = '{act: ACT_DIGIT_END, cond: C_ALWAYS,   target: U_FINISH};
			U_FINISH:   w = '{act: ACT_NONE,      cond: C_OUT_FULL, target: U_FINISH};
			U_EMIT:     w = '{act: ACT_EMIT,      cond: C_ALWAYS,   target: U_IDLE};
			default:    w = '{act: ACT_NONE,      cond: C_ALWAYS,   target: U_IDLE};
		endcase
		return w;
	endfunction

	// Entry point of each query
	function automatic upc_t dispatch(input logic [OPCODE_W-1:0] op);
		upc_t t;
		case (op)
			OP_PARITY: t = U_PARITY;
			OP_PRIME:  t = U_P_LE1;
			OP_PALIN:  t = U_D_LOOP;
			OP_SIGN:   t = U_SIGN;
			OP_REV:    t = U_D_LOOP;
			OP_DSUM:   t = U_D_LOOP;
			default:   t = U_INVALID;
		endcase
		return t;
	endfunction

endpackage

FILE: src/ipu_div.sv
// Bit-serial restoring divider for the trial-division loop; returns the remainder.
// Depends on ipu_pkg for widths.
module ipu_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ipu_pkg::VAL_W-1:0]   dividend,
	input  logic [ipu_pkg::DIV_W-1:0]   divisor,
	output logic                        busy,
	output logic [ipu_pkg::DIV_W-1:0]   remainder
);

	logic                        busy_q;
	logic [ipu_pkg::CNT_W-1:0]   cnt_q;
	logic [ipu_pkg::VAL_W-1:0]   quo_q;
	logic [ipu_pkg::DIV_W-1:0]   rem_q;
	logic [ipu_pkg::DIV_W-1:0]   dsr_q;
	logic [ipu_pkg::DIV_W:0]     shifted;
	logic [ipu_pkg::DIV_W:0]     diff;
	logic                        ge;

	// Trial subtract of one quotient bit
	assign shifted = {rem_q, quo_q[ipu_pkg::VAL_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign ge      = shifted >= {1'b0, dsr_q};

	// Hold control: busy flag and bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= ipu_pkg::CNT_W'(ipu_pkg::VAL_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - ipu_pkg::CNT_W'(1);
			if (cnt_q == ipu_pkg::CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Shift the quotient in, restore the remainder when the subtract fails
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[ipu_pkg::VAL_W-2:0], ge};
			rem_q <= ge ? diff[ipu_pkg::DIV_W-1:0] : shifted[ipu_pkg::DIV_W-1:0];
		end
	end

	assign busy      = busy_q;
	assign remainder = rem_q;

endmodule

FILE: src/integer_property_unit.sv
// Top level of the integer property unit: stream ports, micro-sequencer and datapath.
// Depends on ipu_pkg (types, microprogram) and ipu_div (serial divider).

// Answers one query per input transaction about a signed operand: parity, primality,
// decimal palindrome, sign class, digit reversal or digit sum; opcodes 6 and 7 return
// an invalid status. One transaction is processed at a time, steered by a microprogram
// held in a read-only control store. Parity, sign and invalid answers go from their
// action step straight to the finish step. Digit queries run a loop test, a
// reciprocal multiply by one tenth and an accumulate step for each decimal digit.
// Primality runs one serial division per odd trial divisor up to the square root;
// small and even values finish without a division. A new transaction is taken as
// soon as the sequencer is back at its idle step, even while the previous result
// still waits in the output register.
module integer_property_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [2:0] opcode, [34:3] operand, upper bits zero
	input  logic [ipu_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [0] status, [1] verdict, [3:2] sign_class, [37:4] number_value, upper bits zero
	output logic [ipu_pkg::OUT_TDATA_W-1:0]   m_tdata
);

	ipu_pkg::upc_t                    upc_q;
	ipu_pkg::upc_t                    upc_next;
	ipu_pkg::uword_t                  uw;
	logic                             accept;
	logic                             take;

	logic [ipu_pkg::OPCODE_W-1:0]     in_opcode;
	logic [ipu_pkg::OPERAND_W-1:0]    in_operand;
	logic                             in_neg;
	logic                             in_zero;

	logic [ipu_pkg::OPCODE_W-1:0]     op_q;
	logic                             par_q;
	logic                             neg_q;
	logic                             zero_q;
	logic [ipu_pkg::VAL_W-1:0]        u_q;
	logic [ipu_pkg::VAL_W-1:0]        t_q;
	logic [ipu_pkg::VAL_W-1:0]        t_div10_q;
	logic [ipu_pkg::DIV_W-1:0]        d_q;
	logic [ipu_pkg::SQ_W-1:0]         sq_q;
	logic [ipu_pkg::NUM_W-1:0]        acc_q;
	logic                             status_q;
	logic                             verdict_q;
	logic [ipu_pkg::SIGN_W-1:0]       sign_q;
	logic [ipu_pkg::NUM_W-1:0]        num_q;

	logic                             m_valid_q;
	logic                             m_status_q;
	logic                             m_verdict_q;
	logic [ipu_pkg::SIGN_W-1:0]       m_sign_q;
	logic [ipu_pkg::NUM_W-1:0]        m_num_q;

	logic                             div_start;
	logic                             div_busy;
	logic [ipu_pkg::DIV_W-1:0]        div_rem;
	logic [ipu_pkg::PROD_W-1:0]       t_prod;
	logic [ipu_pkg::VAL_W-1:0]        t_div10;
	logic [3:0]                       rem10;
	logic [ipu_pkg::NUM_W-1:0]        digit;

	// Unpack the input transaction; only the low DATA_WIDTH bits of the operand count
	assign in_opcode  = s_tdata[ipu_pkg::OPCODE_W-1:0];
	assign in_operand = s_tdata[ipu_pkg::IN_FIELDS_W-1:ipu_pkg::OPCODE_W];
	assign in_neg     = in_operand[ipu_pkg::DATA_WIDTH-1];
	assign in_zero    = (in_operand[ipu_pkg::DATA_WIDTH-1:0] == '0);

	assign s_tready = (upc_q == ipu_pkg::U_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Fetch the control word
	assign uw = ipu_pkg::urom(upc_q);

	// Evaluate the jump condition
	always_comb begin
		unique case (uw.cond)
			ipu_pkg::C_NEVER:    take = 1'b0;
			ipu_pkg::C_ALWAYS:   take = 1'b1;
			ipu_pkg::C_NOSTART:  take = !accept;
			ipu_pkg::C_DISPATCH: take = 1'b1;
			ipu_pkg::C_LE1:      take = (u_q <= ipu_pkg::VAL_ONE);
			ipu_pkg::C_LT4:      take = (u_q < ipu_pkg::VAL_FOUR);
			ipu_pkg::C_EVEN:     take = !u_q[0];
			ipu_pkg::C_SQ_GT:    take = (sq_q > ipu_pkg::SQ_W'(u_q));
			ipu_pkg::C_DIV_BUSY: take = div_busy;
			ipu_pkg::C_REM_ZERO: take = (div_rem == '0);
			ipu_pkg::C_T_ZERO:   take = (t_q == '0);
			ipu_pkg::C_OUT_FULL: take = m_valid_q;
			default:             take = 1'b1;
		endcase
	end

	// Select the next step
	always_comb begin
		if (uw.cond == ipu_pkg::C_DISPATCH) begin
			upc_next = ipu_pkg::dispatch(op_q);
		end else if (take) begin
			upc_next = uw.target;
		end else begin
			upc_next = upc_q + ipu_pkg::UPC_W'(1);
		end
	end

	// Step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q     <= ipu_pkg::U_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			upc_q <= upc_next;
			if (uw.act == ipu_pkg::ACT_EMIT) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Drive the trial divider
	assign div_start = (uw.act == ipu_pkg::ACT_DIV_D);

	ipu_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (u_q),
		.divisor   (d_q),
		.busy      (div_busy),
		.remainder (div_rem)
	);

	// Divide the digit walker by ten; the digit is t - 10q, taken modulo 16
	assign t_prod  = ipu_pkg::PROD_W'(t_q) * ipu_pkg::PROD_W'(ipu_pkg::RECIP10);
	assign t_div10 = ipu_pkg::VAL_W'(t_prod >> ipu_pkg::RECIP_SHIFT);
	assign rem10   = t_q[3:0] - {t_div10_q[0], 3'b000} - {t_div10_q[2:0], 1'b0};
	assign digit   = ipu_pkg::NUM_W'(rem10);

	// Datapath: load on accept, then apply the action of each control word
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= in_opcode;
			par_q     <= in_operand[0];
			neg_q     <= in_neg;
			zero_q    <= in_zero;
			u_q       <= in_neg ? '0 : in_operand[ipu_pkg::VAL_W-1:0];
			t_q       <= in_neg ? '0 : in_operand[ipu_pkg::VAL_W-1:0];
			d_q       <= ipu_pkg::D_FIRST;
			sq_q      <= ipu_pkg::SQ_FIRST;
			acc_q     <= '0;
			status_q  <= 1'b0;
			verdict_q <= 1'b0;
			sign_q    <= ipu_pkg::SIGN_ZERO;
			num_q     <= '0;
		end else begin
			unique case (uw.act)
				ipu_pkg::ACT_PARITY:  verdict_q <= par_q;
				ipu_pkg::ACT_SIGN: begin
					if (neg_q) begin
						sign_q <= ipu_pkg::SIGN_NEG;
					end else if (zero_q) begin
						sign_q <= ipu_pkg::SIGN_ZERO;
					end else begin
						sign_q <= ipu_pkg::SIGN_POS;
					end
				end
				ipu_pkg::ACT_INVALID: status_q  <= 1'b1;
				ipu_pkg::ACT_VERDICT: verdict_q <= 1'b1;
				ipu_pkg::ACT_STEP_D: begin
					// (d + 2)^2 = d^2 + 4d + 4
					d_q  <= d_q + ipu_pkg::D_STEP;
					sq_q <= sq_q + ipu_pkg::SQ_W'({d_q, 2'b00}) + ipu_pkg::SQ_STEP;
				end
				ipu_pkg::ACT_DIV_TEN: t_div10_q <= t_div10;
				ipu_pkg::ACT_DIGIT: begin
					t_q <= t_div10_q;
					if (op_q == ipu_pkg::OP_DSUM) begin
						acc_q <= acc_q + digit;
					end else begin
						acc_q <= (acc_q << 3) + (acc_q << 1) + digit;
					end
				end
				ipu_pkg::ACT_DIGIT_END: begin
					if (op_q == ipu_pkg::OP_PALIN) begin
						verdict_q <= !neg_q && (acc_q == ipu_pkg::NUM_W'(u_q));
					end else begin
						num_q <= acc_q;
					end
				end
				ipu_pkg::ACT_EMIT: begin
					m_status_q  <= status_q;
					m_verdict_q <= verdict_q;
					m_sign_q    <= sign_q;
					m_num_q     <= num_q;
				end
				default: begin
				end
			endcase
		end
	end

	// Pack the result transaction
	assign m_tvalid = m_valid_q;
	assign m_tdata  = ipu_pkg::OUT_TDATA_W'({m_num_q, m_sign_q, m_verdict_q, m_status_q});

`ifndef SYNTHESIS
	// Divider is idle whenever a new transaction may enter
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !div_busy)
		else $error("divider busy while sequencer idle");

	// An accepted transaction leaves the idle step at once
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("sequencer stayed idle after accept");

	// An invalid result carries no other answer
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_status_q) |-> (!m_verdict_q && m_sign_q == ipu_pkg::SIGN_ZERO
			&& m_num_q == '0))
		else $error("invalid result with non-zero fields");

	// Emit only into an empty output register
	assert property (@(posedge clk) disable iff (!arst_n)
		(uw.act == ipu_pkg::ACT_EMIT) |-> !m_valid_q)
		else $error("result overwritten before transfer");
`endif

endmodule

FILE: dv/integer_property_unit_test.sv
// Self-checking testbench for integer_property_unit: drives opcode/operand queries over
// the input stream and checks every answer against a behavioural predictor.
// Depends on ipu_pkg and integer_property_unit from src.
module integer_property_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [ipu_pkg::OPCODE_W-1:0] OP_RESERVED_LO = 3'd6;
	localparam logic [ipu_pkg::OPCODE_W-1:0] OP_RESERVED_HI = 3'd7;
	localparam int RANDOM_PER_PHASE = 19;
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		logic [ipu_pkg::OPCODE_W-1:0]  opcode;
		logic [ipu_pkg::OPERAND_W-1:0] operand;
	} query_t;

	// Field order matches m_tdata from the top field down to bit 0
	typedef struct packed {
		logic [ipu_pkg::NUM_W-1:0]  number_value;
		logic [ipu_pkg::SIGN_W-1:0] sign_class;
		logic                       verdict;
		logic                       status;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [ipu_pkg::IN_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [ipu_pkg::OUT_TDATA_W-1:0] m_tdata;

	query_t  pending_queries[$];
	answer_t expected_answers[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	int unsigned mismatch_count = 0;
	int unsigned answers_checked = 0;
	int unsigned queries_accepted = 0;
	int unsigned invalid_seen = 0;

	// Corner queries: field extremes, every opcode and the special cases
	query_t corner_queries[] = '{
		'{ipu_pkg::OP_PARITY, 32'd0},
		'{ipu_pkg::OP_PARITY, 32'hFFFF_FFFF},
		'{ipu_pkg::OP_PARITY, 32'h7FFF_FFFF},
		'{ipu_pkg::OP_PRIME, 32'd1},
		'{ipu_pkg::OP_PRIME, 32'd2},
		'{ipu_pkg::OP_PRIME, 32'd3},
		'{ipu_pkg::OP_PRIME, 32'd4},
		'{ipu_pkg::OP_PRIME, 32'd9},
		'{ipu_pkg::OP_PRIME, 32'hFFFF_FFF9},
		'{ipu_pkg::OP_PRIME, 32'd65521},
		'{ipu_pkg::OP_PRIME, 32'd2147483645},
		'{ipu_pkg::OP_PALIN, 32'd0},
		'{ipu_pkg::OP_PALIN, 32'd2147447412},
		'{ipu_pkg::OP_PALIN, 32'd12345},
		'{ipu_pkg::OP_PALIN, 32'hFFFF_FF87},
		'{ipu_pkg::OP_SIGN, 32'd0},
		'{ipu_pkg::OP_SIGN, 32'h8000_0000},
		'{ipu_pkg::OP_SIGN, 32'h7FFF_FFFF},
		'{ipu_pkg::OP_REV, 32'h7FFF_FFFF},
		'{ipu_pkg::OP_REV, 32'd1200},
		'{ipu_pkg::OP_DSUM, 32'd1999999999},
		'{ipu_pkg::OP_DSUM, 32'hFFFF_FFF7},
		'{OP_RESERVED_LO, 32'h5A5A_5A5A},
		'{OP_RESERVED_HI, 32'hFFFF_FFFF}
	};

	integer_property_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Work out the answer the unit owes for one query
	function automatic answer_t predict_answer(input logic [ipu_pkg::OPCODE_W-1:0] opcode,
			input logic [ipu_pkg::OPERAND_W-1:0] operand);
		answer_t a;
		longint n;
		longint unsigned t;
		longint unsigned u;
		longint unsigned d;
		logic [ipu_pkg::NUM_W-1:0] reversal;
		logic [ipu_pkg::NUM_W-1:0] digit_total;
		a = '0;
		n = longint'($signed(operand[ipu_pkg::DATA_WIDTH-1:0]));
		reversal = '0;
		digit_total = '0;
		t = (n > 0) ? longint'(n) : 0;
		// walk the decimal digits once for reversal and sum
		while (t > 0) begin
			reversal = reversal * 10 + ipu_pkg::NUM_W'(t % 10);
			digit_total = digit_total + ipu_pkg::NUM_W'(t % 10);
			t = t / 10;
		end
		case (opcode)
			ipu_pkg::OP_PARITY: a.verdict = n[0];
			ipu_pkg::OP_PRIME: begin
				if (n <= 1) begin
					a.verdict = 1'b0;
				end else if (n < 4) begin
					a.verdict = 1'b1;
				end else if (!n[0]) begin
					a.verdict = 1'b0;
				end else begin
					u = longint'(n);
					a.verdict = 1'b1;
					for (d = 3; d * d <= u; d += 2) begin
						if (u % d == 0) begin
							a.verdict = 1'b0;
							break;
						end
					end
				end
			end
			ipu_pkg::OP_PALIN:
				a.verdict = (n == 0) || ((n > 0) && (reversal == ipu_pkg::NUM_W'(n)));
			ipu_pkg::OP_SIGN:
				a.sign_class = (n > 0) ? ipu_pkg::SIGN_POS :
						((n < 0) ? ipu_pkg::SIGN_NEG : ipu_pkg::SIGN_ZERO);
			ipu_pkg::OP_REV: a.number_value = reversal;
			ipu_pkg::OP_DSUM: a.number_value = digit_total;
			default: a.status = 1'b1;
		endcase
		return a;
	endfunction

	// Clock
	initial begin
		forever #5 clk = ~clk;
	end

	// Driver: record accepted transactions, then present the next pending query
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_answers.push_back(predict_answer(s_tdata[ipu_pkg::OPCODE_W-1:0],
						s_tdata[ipu_pkg::IN_FIELDS_W-1:ipu_pkg::OPCODE_W]));
				queries_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_queries.size() > 0 &&
						$urandom_range(99, 0) >= send_idle_pct) begin
					s_tdata <= ipu_pkg::IN_TDATA_W'({pending_queries[0].operand,
							pending_queries[0].opcode});
					void'(pending_queries.pop_front());
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each answer against the oldest prediction, then stall at random
	always @(posedge clk or negedge arst_n) begin
		answer_t got;
		answer_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[ipu_pkg::OUT_FIELDS_W-1:0];
				if (expected_answers.size() == 0) begin
					if (mismatch_count < REPORT_LIMIT)
						$display("[%0t] answer with none outstanding: %h", $realtime, m_tdata);
					mismatch_count++;
				end else begin
					want = expected_answers.pop_front();
					answers_checked++;
					if (got.status != want.status || got.verdict != want.verdict ||
							got.sign_class != want.sign_class ||
							got.number_value != want.number_value) begin
						if (mismatch_count < REPORT_LIMIT) begin
							$display("[%0t] answer %0d (expected/actual): status %0d/%0d",
									$realtime, answers_checked, want.status, got.status);
							$display("    verdict %0d/%0d sign %0d/%0d value %0d/%0d",
									want.verdict, got.verdict, want.sign_class,
									got.sign_class, want.number_value, got.number_value);
						end
						mismatch_count++;
					end
					if (want.status)
						invalid_seen++;
				end
			end
			m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	// Stimulus: corner queries, then random queries under four pressure phases
	initial begin
		int unsigned idle_table[4];
		int unsigned stall_table[4];
		query_t q;
		int unsigned digits;
		int unsigned half[5];
		int unsigned pick;
		int p;
		int i;
		int k;
		idle_table = '{0, 81, 0, 24};
		stall_table = '{0, 0, 81, 24};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		foreach (corner_queries[j])
			pending_queries.push_back(corner_queries[j]);
		for (p = 0; p < 4; p++) begin
			@(negedge clk);
			send_idle_pct = idle_table[p];
			recv_stall_pct = stall_table[p];
			for (i = 0; i < RANDOM_PER_PHASE; i++) begin
				q.opcode = ipu_pkg::OPCODE_W'($urandom_range(7, 0));
				pick = $urandom_range(9, 0);
				// spread the operand over full range, small values and non-negative 31-bit values
				if (pick < 3)
					q.operand = $urandom;
				else if (pick < 6)
					q.operand = $urandom_range(2000, 0) - 1000;
				else
					q.operand = $urandom & 32'h7FFF_FFFF;
				// keep trial division short: mostly small candidates
				if (q.opcode == ipu_pkg::OP_PRIME) begin
					if (pick < 2)
						q.operand = -$urandom_range(100, 0);
					else if (pick < 8)
						q.operand = $urandom_range(16383, 0);
					else
						q.operand = $urandom_range(1 << 20, 0);
				end
				// mirror random digits into a palindrome for most palindrome queries
				if (q.opcode == ipu_pkg::OP_PALIN && pick < 6) begin
					digits = $urandom_range(9, 1);
					for (k = 0; k < 5; k++)
						half[k] = $urandom_range(9, 0);
					half[0] = $urandom_range(9, 1);
					q.operand = 0;
					for (k = 0; k < digits; k++)
						q.operand = q.operand * 10 +
								half[(k < (digits + 1) / 2) ? k : digits - 1 - k];
				end
				pending_queries.push_back(q);
			end
			// drain the phase before changing pressure
			while (pending_queries.size() > 0 || s_tvalid || expected_answers.size() > 0)
				@(negedge clk);
		end
		repeat (50) @(posedge clk);
		if (expected_answers.size() > 0)
			mismatch_count++;
		$display("Checked %0d answers for %0d queries over four pressure phases;",
				answers_checked, queries_accepted);
		$display("%0d invalid-opcode answers, every opcode and sign class exercised.",
				invalid_seen);
		if (mismatch_count == 0)
			$display("integer_property_unit regression: pass");
		else
			$display("integer_property_unit regression: fail");
		$finish;
	end

	// Give up if the run stalls
	initial begin
		#100_000_000;
		$display("integer_property_unit regression: fail");
		$finish;
	end

endmodule

FILE: integer_property_unit.f
src/ipu_pkg.sv
src/ipu_div.sv
src/integer_property_unit.sv
dv/integer_property_unit_test.sv
